[rtl/bvt_pkg.sv]
// ----------------------------------------------------------------------------
// B-V tint package
// Shared widths, Q4.28 fixed-point type, locus and matrix constants, and the
// rounding fixed-point multiply used by the tint pipeline.
// ----------------------------------------------------------------------------
package bvt_pkg;

  localparam int IN_FRAC_BITS_DEF  = 10;
  localparam int OUT_FRAC_BITS_DEF = 13;
  localparam int BV_W              = 13;
  localparam int TINT_W            = 16;
  localparam int Q_FRAC            = 28;

  // Signed Q.28 value; every internal quantity stays well inside +/-16.
  typedef logic signed [32:0] q_t;

  localparam longint Q_SCALE = 64'sd268435456;

  localparam q_t Q_ONE  = q_t'(Q_SCALE);
  localparam q_t K_TWO  = q_t'(2 * Q_SCALE);
  localparam q_t K_0P4  = q_t'((4 * Q_SCALE + 10 / 2) / 10);
  localparam q_t K_TINY = q_t'((1 * Q_SCALE + 1000000 / 2) / 1000000);

  // Ballesteros denominators.
  localparam q_t K_092  = q_t'((92 * Q_SCALE + 100 / 2) / 100);
  localparam q_t K_1P7  = q_t'((17 * Q_SCALE + 10 / 2) / 10);
  localparam q_t K_0P62 = q_t'((62 * Q_SCALE + 100 / 2) / 100);

  // Chromaticity x against 1000/T, below 4000 K.
  localparam q_t KXL3 = -q_t'((2661239 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KXL2 = -q_t'((2343589 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KXL1 = q_t'((8776956 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KXL0 = q_t'((179910 * Q_SCALE + 1000000 / 2) / 1000000);
  // Chromaticity x, 4000 K and above.
  localparam q_t KXH3 = -q_t'((30258469 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KXH2 = q_t'((21070379 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KXH1 = q_t'((2226347 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KXH0 = q_t'((240390 * Q_SCALE + 1000000 / 2) / 1000000);

  // Chromaticity y against x, three temperature bands.
  localparam q_t KYL3 = -q_t'((11063814 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KYL2 = -q_t'((134811020 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYL1 = q_t'((218555832 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYL0 = -q_t'((20219683 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYM3 = -q_t'((9549476 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KYM2 = -q_t'((137418593 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYM1 = q_t'((209137015 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYM0 = -q_t'((16748867 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYH3 = q_t'((30817580 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t KYH2 = -q_t'((587338670 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYH1 = q_t'((375112997 * Q_SCALE + 100000000 / 2) / 100000000);
  localparam q_t KYH0 = -q_t'((37001483 * Q_SCALE + 100000000 / 2) / 100000000);

  // XYZ to linear sRGB (D65) with Y = 1; the middle column is the offset.
  localparam q_t K_RX = q_t'((32404542 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_RC = -q_t'((15371385 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_RZ = -q_t'((4985314 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_GX = -q_t'((9692660 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_GC = q_t'((18760108 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_GZ = q_t'((415560 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_BX = q_t'((556434 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_BC = -q_t'((2040259 * Q_SCALE + 10000000 / 2) / 10000000);
  localparam q_t K_BZ = q_t'((10572252 * Q_SCALE + 10000000 / 2) / 10000000);

  // Rec.709 luminance weights.
  localparam q_t K_LR = q_t'((2126 * Q_SCALE + 10000 / 2) / 10000);
  localparam q_t K_LG = q_t'((7152 * Q_SCALE + 10000 / 2) / 10000);
  localparam q_t K_LB = q_t'((722 * Q_SCALE + 10000 / 2) / 10000);

  // Q.28 product, rounded to nearest with ties away from zero.
  function automatic q_t mulq(input q_t a, input q_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;
    q_t          res;
    ma   = a[32] ? 32'(-a) : 32'(a);
    mb   = b[32] ? 32'(-b) : 32'(b);
    prod = 64'(ma) * 64'(mb) + (64'd1 << (Q_FRAC - 1));
    res  = q_t'(prod[63:Q_FRAC]);
    return (a[32] ^ b[32]) ? -res : res;
  endfunction

endpackage

[rtl/bvt_if.sv]
// ----------------------------------------------------------------------------
// B-V tint channels
// Valid/ready channel for colour-index requests and one for tint results.
// ----------------------------------------------------------------------------
interface bvt_in_if import bvt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [BV_W-1:0] colour_index;

  modport source (output valid, output colour_index, input ready);
  modport sink (input valid, input colour_index, output ready);
endinterface

interface bvt_out_if import bvt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TINT_W-1:0] tint_red;
  logic [TINT_W-1:0] tint_green;
  logic [TINT_W-1:0] tint_blue;

  modport source (output valid, output tint_red, output tint_green, output tint_blue,
                  input ready);
  modport sink (input valid, input tint_red, input tint_green, input tint_blue,
                output ready);
endinterface

[rtl/bvt_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the caller guarantees that the
// quotient fits in QW bits. Side data travels alongside each request.
// ----------------------------------------------------------------------------
module bvt_div #(
  parameter int NW = 57,
  parameter int DW = 30,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] acc [QW];
  logic [DW-1:0] dv  [QW];
  logic [SW-1:0] sd  [QW];
  logic          vld [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] a_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign r_in = DW'(num >> QW);
      assign a_in = num[QW-1:0];
      assign d_in = den;
      assign s_in = side;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign a_in = acc[i-1];
      assign d_in = dv[i-1];
      assign s_in = sd[i-1];
      assign v_in = vld[i-1];
    end

    assign trial = {r_in, a_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        acc[i] <= {a_in[QW-2:0], ge};
        dv[i]  <= d_in;
        sd[i]  <= s_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = acc[QW-1];
  assign side_out  = sd[QW-1];

endmodule

[rtl/bvt_skid.sv]
// ----------------------------------------------------------------------------
// Output register with skid stage
// Holds results for the consumer and freezes the pipeline only when both
// the output register and the skid register are occupied.
// ----------------------------------------------------------------------------
module bvt_skid #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         en,
  output logic         out_valid,
  output logic [W-1:0] out_data,
  input  logic         out_ready
);

  logic         ov;
  logic         sv;
  logic [W-1:0] od;
  logic [W-1:0] skd;
  logic         load;

  assign en        = !sv;
  assign load      = out_ready || !ov;
  assign out_valid = ov;
  assign out_data  = od;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (load) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= in_valid;
      end
    end else if (in_valid && !sv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      od <= sv ? skd : in_data;
    end else if (in_valid && !sv) begin
      skd <= in_data;
    end
  end

endmodule

[rtl/bv_index_to_rgb_tint.sv]
// ----------------------------------------------------------------------------
// B-V colour index to linear sRGB tint
// Clamps B-V, finds the blackbody temperature, walks the Planckian locus,
// converts to linear sRGB and normalises each component to unit luminance.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                   handshake
//   bv       in   colour_index (13 b signed, B-V)           valid/ready
//   tint     out  tint_red, tint_green, tint_blue (16 b)    valid/ready
//
// One request enters per clock while the pipeline is not frozen. The chain
// holds four bit-serial dividers (31 + 28 + 32 + 16 stages), eighteen
// arithmetic stages and the output register. Reset is synchronous and
// clears only the valid bits. When the consumer stalls, the output
// register and a skid register absorb results; the whole pipeline freezes,
// and bv.ready falls, only once both are full.
// ----------------------------------------------------------------------------
module bv_index_to_rgb_tint import bvt_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bvt_in_if.sink   bv,
  bvt_out_if.source tint
);

  localparam int SH  = Q_FRAC - IN_FRAC_BITS;
  localparam int NWE = 32 + OUT_FRAC_BITS + 1;

  // Temperature limits and branch points in Q.8 kelvin.
  localparam logic [22:0] T8_MIN  = 23'(1667 * 256);
  localparam logic [22:0] T8_MAX  = 23'(25000 * 256);
  localparam logic [22:0] T8_4000 = 23'(4000 * 256);
  localparam logic [22:0] T8_2222 = 23'(2222 * 256);

  localparam logic [56:0] N_A = 57'd1 << 56;
  localparam logic [45:0] N_C = 46'd1000 << 36;

  // Global advance: every stage moves together unless the skid is full.
  logic en;
  assign bv.ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: scale B-V to Q.28 and clamp it to the fitted range.
  // --------------------------------------------------------------------------
  logic signed [35:0] bvw;
  q_t                 bv_c;
  logic               v1;
  q_t                 bv1;

  always_comb begin
    bvw = 36'(bv.colour_index) <<< SH;
    if (bvw < 36'(-K_0P4)) begin
      bv_c = -K_0P4;
    end else if (bvw > 36'(K_TWO)) begin
      bv_c = K_TWO;
    end else begin
      bv_c = q_t'(bvw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= bv.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bv1 <= bv_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the two Ballesteros denominators, floored at one LSB.
  // --------------------------------------------------------------------------
  q_t          x_s2;
  q_t          d1c;
  q_t          d2c;
  logic        v2;
  logic [29:0] da1;
  logic [29:0] da2;

  always_comb begin
    x_s2 = mulq(K_092, bv1);
    d1c  = x_s2 + K_1P7;
    d2c  = x_s2 + K_0P62;
    if (d1c < 33'sd1) begin
      d1c = 33'sd1;
    end
    if (d2c < 33'sd1) begin
      d2c = 33'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da1 <= d1c[29:0];
      da2 <= d2c[29:0];
    end
  end

  // Reciprocals 2^56 / d, rounded to nearest.
  logic        va;
  logic [30:0] qa1;
  logic [30:0] qa2;
  logic [56:0] na1;
  logic [56:0] na2;

  assign na1 = N_A + 57'(da1 >> 1);
  assign na2 = N_A + 57'(da2 >> 1);

  bvt_div #(.NW(57), .DW(30), .QW(31), .SW(1)) u_div_rcp1 (
    .clk, .rst, .en,
    .in_valid (v2),
    .num      (na1),
    .den      (da1),
    .side     (1'b0),
    .out_valid(va),
    .quo      (qa1),
    .side_out ()
  );

  bvt_div #(.NW(57), .DW(30), .QW(31), .SW(1)) u_div_rcp2 (
    .clk, .rst, .en,
    .in_valid (v2),
    .num      (na2),
    .den      (da2),
    .side     (1'b0),
    .out_valid(),
    .quo      (qa2),
    .side_out ()
  );

  // --------------------------------------------------------------------------
  // Stage 3: sum of reciprocals times 4600.
  // Stage 4: round to Q.8 kelvin, clamp, and pick the locus branches.
  // --------------------------------------------------------------------------
  logic [31:0] s_sum;
  logic        v3;
  logic [44:0] p3;

  assign s_sum = {1'b0, qa1} + {1'b0, qa2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3 <= 45'(s_sum) * 45'd4600;
    end
  end

  logic [24:0] t8w;
  logic [22:0] t8c;
  logic        v4;
  logic [22:0] t8r;
  logic [1:0]  f4;

  always_comb begin
    t8w = 25'((p3 + 45'd524288) >> 20);
    if (t8w < 25'(T8_MIN)) begin
      t8c = T8_MIN;
    end else if (t8w > 25'(T8_MAX)) begin
      t8c = T8_MAX;
    end else begin
      t8c = t8w[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  // f4[1] marks below 4000 K, f4[0] below 2222 K.
  always_ff @(posedge clk) begin
    if (en) begin
      t8r <= t8c;
      f4  <= {t8c < T8_4000, t8c < T8_2222};
    end
  end

  // Reciprocal temperature 1000/T in Q.28.
  logic [45:0] nc;
  logic        vc;
  logic [27:0] qc;
  logic [1:0]  fc;

  assign nc = N_C + 46'(t8r >> 1);

  bvt_div #(.NW(46), .DW(23), .QW(28), .SW(2)) u_div_recip_t (
    .clk, .rst, .en,
    .in_valid (v4),
    .num      (nc),
    .den      (t8r),
    .side     (f4),
    .out_valid(vc),
    .quo      (qc),
    .side_out (fc)
  );

  // --------------------------------------------------------------------------
  // Stages 5 to 8: powers of 1000/T and the chromaticity x cubic.
  // --------------------------------------------------------------------------
  q_t         t1_5;
  q_t         t2_5;
  logic [1:0] f5;
  logic       v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_5 <= q_t'(qc);
      t2_5 <= mulq(q_t'(qc), q_t'(qc));
      f5   <= fc;
    end
  end

  q_t         t1_6;
  q_t         t2_6;
  q_t         t3_6;
  logic [1:0] f6;
  logic       v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_6 <= t1_5;
      t2_6 <= t2_5;
      t3_6 <= mulq(t2_5, t1_5);
      f6   <= f5;
    end
  end

  q_t         kx3;
  q_t         kx2;
  q_t         kx1;
  q_t         kx0;
  q_t         cxp3;
  q_t         cxp2;
  q_t         cxp1;
  q_t         cx0_7;
  logic [1:0] f7;
  logic       v7;

  always_comb begin
    kx3 = f6[1] ? KXL3 : KXH3;
    kx2 = f6[1] ? KXL2 : KXH2;
    kx1 = f6[1] ? KXL1 : KXH1;
    kx0 = f6[1] ? KXL0 : KXH0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cxp3  <= mulq(kx3, t3_6);
      cxp2  <= mulq(kx2, t2_6);
      cxp1  <= mulq(kx1, t1_6);
      cx0_7 <= kx0;
      f7    <= f6;
    end
  end

  q_t         cx8;
  logic [1:0] f8;
  logic       v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx8 <= cxp3 + cxp2 + cxp1 + cx0_7;
      f8  <= f7;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9 to 12: powers of x and the three-band chromaticity y cubic.
  // --------------------------------------------------------------------------
  q_t         cx9;
  q_t         x2_9;
  logic [1:0] f9;
  logic       v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx9  <= cx8;
      x2_9 <= mulq(cx8, cx8);
      f9   <= f8;
    end
  end

  q_t         cx10;
  q_t         x2_10;
  q_t         x3_10;
  logic [1:0] f10;
  logic       v10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx10  <= cx9;
      x2_10 <= x2_9;
      x3_10 <= mulq(x2_9, cx9);
      f10   <= f9;
    end
  end

  q_t   ky3;
  q_t   ky2;
  q_t   ky1;
  q_t   ky0;
  q_t   cyp3;
  q_t   cyp2;
  q_t   cyp1;
  q_t   cy0_11;
  q_t   cx11;
  logic v11;

  always_comb begin
    if (f10[0]) begin
      ky3 = KYL3;
      ky2 = KYL2;
      ky1 = KYL1;
      ky0 = KYL0;
    end else if (f10[1]) begin
      ky3 = KYM3;
      ky2 = KYM2;
      ky1 = KYM1;
      ky0 = KYM0;
    end else begin
      ky3 = KYH3;
      ky2 = KYH2;
      ky1 = KYH1;
      ky0 = KYH0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyp3   <= mulq(ky3, x3_10);
      cyp2   <= mulq(ky2, x2_10);
      cyp1   <= mulq(ky1, cx10);
      cy0_11 <= ky0;
      cx11   <= cx10;
    end
  end

  q_t   cx12;
  q_t   cy12;
  logic v12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else if (en) begin
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx12 <= cx11;
      cy12 <= cyp3 + cyp2 + cyp1 + cy0_11;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13: floor y, form 1 - x - y, and split both numerators into sign
  // and magnitude for the X and Z dividers.
  // --------------------------------------------------------------------------
  q_t          cyf;
  q_t          za;
  logic        v13;
  logic [31:0] cyf13;
  logic [31:0] mx13;
  logic [31:0] mz13;
  logic        sx13;
  logic        sz13;

  always_comb begin
    cyf = (cy12 < K_TINY) ? K_TINY : cy12;
    za  = Q_ONE - cx12 - cy12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else if (en) begin
      v13 <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyf13 <= cyf[31:0];
      sx13  <= cx12[32];
      sz13  <= za[32];
      mx13  <= cx12[32] ? 32'(-cx12) : 32'(cx12);
      mz13  <= za[32] ? 32'(-za) : 32'(za);
    end
  end

  logic [60:0] ndx;
  logic [60:0] ndz;
  logic        vd;
  logic [31:0] qx;
  logic [31:0] qz;
  logic        sxd;
  logic        szd;

  assign ndx = (61'(mx13) << Q_FRAC) + 61'(cyf13 >> 1);
  assign ndz = (61'(mz13) << Q_FRAC) + 61'(cyf13 >> 1);

  bvt_div #(.NW(61), .DW(32), .QW(32), .SW(1)) u_div_xyz_x (
    .clk, .rst, .en,
    .in_valid (v13),
    .num      (ndx),
    .den      (cyf13),
    .side     (sx13),
    .out_valid(vd),
    .quo      (qx),
    .side_out (sxd)
  );

  bvt_div #(.NW(61), .DW(32), .QW(32), .SW(1)) u_div_xyz_z (
    .clk, .rst, .en,
    .in_valid (v13),
    .num      (ndz),
    .den      (cyf13),
    .side     (sz13),
    .out_valid(),
    .quo      (qz),
    .side_out (szd)
  );

  // --------------------------------------------------------------------------
  // Stages 14 and 15: XYZ to linear sRGB, negatives clipped to zero.
  // --------------------------------------------------------------------------
  q_t   xv;
  q_t   zv;
  q_t   prx;
  q_t   prz;
  q_t   pgx;
  q_t   pgz;
  q_t   pbx;
  q_t   pbz;
  logic v14;

  always_comb begin
    xv = sxd ? -q_t'(qx) : q_t'(qx);
    zv = szd ? -q_t'(qz) : q_t'(qz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v14 <= 1'b0;
    end else if (en) begin
      v14 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prx <= mulq(K_RX, xv);
      prz <= mulq(K_RZ, zv);
      pgx <= mulq(K_GX, xv);
      pgz <= mulq(K_GZ, zv);
      pbx <= mulq(K_BX, xv);
      pbz <= mulq(K_BZ, zv);
    end
  end

  q_t   r_s;
  q_t   g_s;
  q_t   b_s;
  q_t   r15;
  q_t   g15;
  q_t   b15;
  logic v15;

  always_comb begin
    r_s = prx + K_RC + prz;
    g_s = pgx + K_GC + pgz;
    b_s = pbx + K_BC + pbz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v15 <= 1'b0;
    end else if (en) begin
      v15 <= v14;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r15 <= r_s[32] ? '0 : r_s;
      g15 <= g_s[32] ? '0 : g_s;
      b15 <= b_s[32] ? '0 : b_s;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 16 and 17: Rec.709 luminance with a floor.
  // --------------------------------------------------------------------------
  q_t   plr;
  q_t   plg;
  q_t   plb;
  q_t   r16;
  q_t   g16;
  q_t   b16;
  logic v16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v16 <= 1'b0;
    end else if (en) begin
      v16 <= v15;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plr <= mulq(K_LR, r15);
      plg <= mulq(K_LG, g15);
      plb <= mulq(K_LB, b15);
      r16 <= r15;
      g16 <= g15;
      b16 <= b15;
    end
  end

  q_t          lum_s;
  logic        v17;
  logic [31:0] r17;
  logic [31:0] g17;
  logic [31:0] b17;
  logic [31:0] lum17;

  always_comb begin
    lum_s = plr + plg + plb;
    if (lum_s < K_TINY) begin
      lum_s = K_TINY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v17 <= 1'b0;
    end else if (en) begin
      v17 <= v16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r17   <= r16[31:0];
      g17   <= g16[31:0];
      b17   <= b16[31:0];
      lum17 <= lum_s[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 18: rounded numerators and the saturation test. A quotient above
  // the 16-bit range shows as the numerator's upper part reaching lum.
  // --------------------------------------------------------------------------
  logic [NWE-1:0] nr_s;
  logic [NWE-1:0] ng_s;
  logic [NWE-1:0] nb_s;
  logic           v18;
  logic [NWE-1:0] nr18;
  logic [NWE-1:0] ng18;
  logic [NWE-1:0] nb18;
  logic [2:0]     sat18;
  logic [31:0]    lum18;

  always_comb begin
    nr_s = (NWE'(r17) << OUT_FRAC_BITS) + NWE'(lum17 >> 1);
    ng_s = (NWE'(g17) << OUT_FRAC_BITS) + NWE'(lum17 >> 1);
    nb_s = (NWE'(b17) << OUT_FRAC_BITS) + NWE'(lum17 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v18 <= 1'b0;
    end else if (en) begin
      v18 <= v17;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr18  <= nr_s;
      ng18  <= ng_s;
      nb18  <= nb_s;
      lum18 <= lum17;
      sat18 <= {(nr_s >> TINT_W) >= NWE'(lum17),
                (ng_s >> TINT_W) >= NWE'(lum17),
                (nb_s >> TINT_W) >= NWE'(lum17)};
    end
  end

  logic              ve;
  logic [TINT_W-1:0] qr;
  logic [TINT_W-1:0] qg;
  logic [TINT_W-1:0] qb;
  logic              satr;
  logic              satg;
  logic              satb;

  bvt_div #(.NW(NWE), .DW(32), .QW(TINT_W), .SW(1)) u_div_red (
    .clk, .rst, .en,
    .in_valid (v18),
    .num      (nr18),
    .den      (lum18),
    .side     (sat18[2]),
    .out_valid(ve),
    .quo      (qr),
    .side_out (satr)
  );

  bvt_div #(.NW(NWE), .DW(32), .QW(TINT_W), .SW(1)) u_div_green (
    .clk, .rst, .en,
    .in_valid (v18),
    .num      (ng18),
    .den      (lum18),
    .side     (sat18[1]),
    .out_valid(),
    .quo      (qg),
    .side_out (satg)
  );

  bvt_div #(.NW(NWE), .DW(32), .QW(TINT_W), .SW(1)) u_div_blue (
    .clk, .rst, .en,
    .in_valid (v18),
    .num      (nb18),
    .den      (lum18),
    .side     (sat18[0]),
    .out_valid(),
    .quo      (qb),
    .side_out (satb)
  );

  // --------------------------------------------------------------------------
  // Saturate and hand over to the output register and skid stage.
  // --------------------------------------------------------------------------
  logic [3*TINT_W-1:0] res_in;
  logic [3*TINT_W-1:0] res_out;

  assign res_in = {satr ? {TINT_W{1'b1}} : qr,
                   satg ? {TINT_W{1'b1}} : qg,
                   satb ? {TINT_W{1'b1}} : qb};

  bvt_skid #(.W(3 * TINT_W)) u_skid (
    .clk, .rst,
    .in_valid (ve),
    .in_data  (res_in),
    .en       (en),
    .out_valid(tint.valid),
    .out_data (res_out),
    .out_ready(tint.ready)
  );

  assign tint.tint_red   = res_out[3*TINT_W-1:2*TINT_W];
  assign tint.tint_green = res_out[2*TINT_W-1:TINT_W];
  assign tint.tint_blue  = res_out[TINT_W-1:0];

endmodule

[test/bvt_tint_checker.sv]
// ----------------------------------------------------------------------------
// B-V tint checker
// Watches the colour-index and tint channels, predicts the tint of every
// accepted request in 64-bit fixed point, and compares it with the result.
// ----------------------------------------------------------------------------
module bvt_tint_checker import bvt_pkg::*; (
  input  logic clk,
  input  logic rst,
  bvt_in_if    bv,
  bvt_out_if   tint,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [TINT_W-1:0] red;
    logic [TINT_W-1:0] green;
    logic [TINT_W-1:0] blue;
  } tint_t;

  localparam longint QONE = 64'sd1 << 28;

  tint_t tint_queue[$];
  int    fails = 0;

  assign fail_count = fails;

  function automatic longint fx(longint n, longint d);
    return (n * QONE + d / 2) / d;
  endfunction

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    if (d == 0) d = 1;
    return (n + d / 2) / d;
  endfunction

  // Q.28 product rounded half away from zero; magnitudes wrap at 64 bits.
  function automatic longint qmul(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r  = (ua * ub + (64'd1 << 27)) >> 28;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    longint unsigned ua;
    longint unsigned r;
    ua = a < 0 ? -a : a;
    r  = rdiv(ua << 28, b);
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint poly3(longint k3, longint k2, longint k1, longint k0,
                                   longint v1, longint v2, longint v3);
    return qmul(k3, v3) + qmul(k2, v2) + qmul(k1, v1) + k0;
  endfunction

  function automatic logic [TINT_W-1:0] norm(longint c, longint lum);
    longint unsigned q;
    q = rdiv(longint'(c) << 13, lum);
    return q > 65535 ? 16'hFFFF : q[15:0];
  endfunction

  function automatic tint_t predict_tint(logic signed [BV_W-1:0] ci);
    longint bvq, xm, d1, d2, t1, t2, t3, cx, x2, x3, cy, cyf, xx, zz, r, g, b, lum;
    longint unsigned s, t8;
    tint_t res;
    bvq = longint'(ci) * (64'sd1 << 18);
    if (bvq < -fx(4, 10)) bvq = -fx(4, 10);
    if (bvq > 2 * QONE) bvq = 2 * QONE;
    xm = qmul(fx(92, 100), bvq);
    d1 = xm + fx(17, 10);
    d2 = xm + fx(62, 100);
    if (d1 < 1) d1 = 1;
    if (d2 < 1) d2 = 1;
    s  = rdiv(64'd1 << 56, d1) + rdiv(64'd1 << 56, d2);
    t8 = rdiv(4600 * s, 64'd1 << 20);
    if (t8 < (64'd1667 << 8)) t8 = 64'd1667 << 8;
    if (t8 > (64'd25000 << 8)) t8 = 64'd25000 << 8;
    t1 = rdiv(64'd1000 << 36, t8);
    t2 = qmul(t1, t1);
    t3 = qmul(t2, t1);
    if (t8 < (64'd4000 << 8))
      cx = poly3(-fx(2661239, 10000000), -fx(2343589, 10000000),
                 fx(8776956, 10000000), fx(179910, 1000000), t1, t2, t3);
    else
      cx = poly3(-fx(30258469, 10000000), fx(21070379, 10000000),
                 fx(2226347, 10000000), fx(240390, 1000000), t1, t2, t3);
    x2 = qmul(cx, cx);
    x3 = qmul(x2, cx);
    if (t8 < (64'd2222 << 8))
      cy = poly3(-fx(11063814, 10000000), -fx(134811020, 100000000),
                 fx(218555832, 100000000), -fx(20219683, 100000000), cx, x2, x3);
    else if (t8 < (64'd4000 << 8))
      cy = poly3(-fx(9549476, 10000000), -fx(137418593, 100000000),
                 fx(209137015, 100000000), -fx(16748867, 100000000), cx, x2, x3);
    else
      cy = poly3(fx(30817580, 10000000), -fx(587338670, 100000000),
                 fx(375112997, 100000000), -fx(37001483, 100000000), cx, x2, x3);
    cyf = cy < fx(1, 1000000) ? fx(1, 1000000) : cy;
    xx  = qdiv(cx, cyf);
    zz  = qdiv(QONE - cx - cy, cyf);
    r = qmul(fx(32404542, 10000000), xx) - fx(15371385, 10000000)
      - qmul(fx(4985314, 10000000), zz);
    g = -qmul(fx(9692660, 10000000), xx) + fx(18760108, 10000000)
      + qmul(fx(415560, 10000000), zz);
    b = qmul(fx(556434, 10000000), xx) - fx(2040259, 10000000)
      + qmul(fx(10572252, 10000000), zz);
    if (r < 0) r = 0;
    if (g < 0) g = 0;
    if (b < 0) b = 0;
    lum = qmul(fx(2126, 10000), r) + qmul(fx(7152, 10000), g) + qmul(fx(722, 10000), b);
    if (lum < fx(1, 1000000)) lum = fx(1, 1000000);
    res.red   = norm(r, lum);
    res.green = norm(g, lum);
    res.blue  = norm(b, lum);
    return res;
  endfunction

  always @(posedge clk) begin
    tint_t want;
    if (!rst) begin
      if (bv.valid && bv.ready) begin
        tint_queue.insert(tint_queue.size(), predict_tint(bv.colour_index));
      end
      if (tint.valid && tint.ready) begin
        if (tint_queue.size() == 0) begin
          $error("tint result with no request outstanding");
          fails++;
        end else begin
          want = tint_queue.pop_front();
          if (tint.tint_red !== want.red) begin
            $error("tint_red: expected %0d, got %0d", want.red, tint.tint_red);
            fails++;
          end
          if (tint.tint_green !== want.green) begin
            $error("tint_green: expected %0d, got %0d", want.green, tint.tint_green);
            fails++;
          end
          if (tint.tint_blue !== want.blue) begin
            $error("tint_blue: expected %0d, got %0d", want.blue, tint.tint_blue);
            fails++;
          end
        end
      end
    end
    pending = tint_queue.size();
  end

endmodule

[test/tb_bv_index_to_rgb_tint.sv]
// ----------------------------------------------------------------------------
// B-V tint testbench
// Drives colour-index requests with random gaps and back-pressure; the
// checker beside the block predicts and compares every tint.
// ----------------------------------------------------------------------------
module tb_bv_index_to_rgb_tint import bvt_pkg::*; ();

  // Allow generously for the pipeline depth and for stalls on both sides.
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   src_idle;
  int   snk_idle;
  int   quiet_cycles = 0;

  bvt_in_if  bv ();
  bvt_out_if tint ();

  bv_index_to_rgb_tint dut (.clk(clk), .rst(rst), .bv(bv), .tint(tint));

  bvt_tint_checker u_checker (
    .clk(clk), .rst(rst), .bv(bv), .tint(tint),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  // The receiver stalls at random, at the rate set for the current phase.
  always @(negedge clk) begin
    tint.ready <= ($urandom_range(99) >= snk_idle);
  end

  // The watchdog counts cycles in which no request and no result moves.
  always @(posedge clk) begin
    if (rst || (bv.valid && bv.ready) || (tint.valid && tint.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, after random idle cycles, and holds it until taken.
  // Each call starts and returns just after a falling edge.
  task automatic send_index(input logic signed [BV_W-1:0] ci);
    while ($urandom_range(99) < src_idle) begin
      bv.valid <= 1'b0;
      @(negedge clk);
    end
    bv.valid        <= 1'b1;
    bv.colour_index <= ci;
    do @(posedge clk); while (!bv.ready);
    @(negedge clk);
  endtask

  // Random index: most lie in the fitted range, where the locus branches
  // change; the rest use the whole field so every bit takes both values.
  function automatic logic signed [BV_W-1:0] random_index();
    case ($urandom_range(3))
      0:       return BV_W'($urandom);
      1:       return BV_W'($urandom_range(1460) + 1340 - 1400);
      default: return BV_W'(int'($urandom_range(2460)) - 412);
    endcase
  endfunction

  // Directed requests: field extremes, both clamp edges of B-V, zero and
  // its neighbours, and indices around the 4000 K branch of the locus.
  logic signed [BV_W-1:0] directed[] = '{
    -13'sd4096, 13'sd4095, -13'sd411, -13'sd410, -13'sd409, 13'sd2047,
    13'sd2048, 13'sd2049, 13'sd0, -13'sd1, 13'sd1, 13'sd1380, 13'sd1390,
    13'sd1396, 13'sd1400, 13'sd1404, 13'sd1410, 13'sd1420, 13'sd512,
    13'sd1024, -13'sd200, -13'sd2048, 13'sd3000
  };

  initial begin
    src_idle        = 37;
    snk_idle        = 81;
    bv.valid        = 1'b0;
    bv.colour_index = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_index(directed[i]);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 37 : (phase == 1) ? 81 : 0;
      snk_idle = (phase == 0) ? 81 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < 200; n++) send_index(random_index());
    end
    bv.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
